>>> rtl/core/tlpt_pkg.sv
// Shared types and sizes for the two-level page table engine.
// Depends on nothing; the front, queue, back and core files refer to it by scoped names.

package tlpt_pkg;

    localparam int NUM_TABLES        = 16;
    localparam int ENTRIES_PER_LEVEL = 1024;

    localparam int LVL_W     = $clog2(ENTRIES_PER_LEVEL);
    localparam int SLOT_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int USED_W    = $clog2(NUM_TABLES + 1);
    localparam int DIR_W     = SLOT_W + 1;
    localparam int TBL_AW    = SLOT_W + LVL_W;
    localparam int TBL_DEPTH = NUM_TABLES * ENTRIES_PER_LEVEL;
    localparam int OFS_W     = 12;
    localparam int FRAME_W   = 32 - OFS_W;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_XLATE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        cmd_t               cmd;
        logic [LVL_W-1:0]   dir_idx;
        logic [LVL_W-1:0]   tbl_idx;
        logic [OFS_W-1:0]   offset;
        logic [31:0]        new_entry;
    } item_t;

    typedef struct packed {
        logic        mapped;
        logic [31:0] phys_result;
        logic        status;
    } result_t;

    // Handshake of the queue toward the back part.
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_XLT  = 3'b100
    } back_state_t;

endpackage

>>> rtl/core/tlpt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for both the directory and the page table store.

module tlpt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tlpt_front.sv
// Front part: accepts request beats, decodes the command and splits the address.
// Depends on tlpt_pkg; feeds tlpt_queue.

module tlpt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tlpt_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          clearing,
    output logic                          push,
    output tlpt_pkg::item_t               push_item,
    input  logic                          q_ready
);

    logic            valid_reg;
    logic            valid_next;
    tlpt_pkg::item_t item_reg;
    tlpt_pkg::item_t item_next;
    logic            accept;
    logic [31:0]     va;
    logic [31:0]     pa;
    logic [11:0]     fl;

    assign va = s_tdata[31:0];
    assign pa = s_tdata[63:32];
    assign fl = s_tdata[75:64];

    assign s_tready = !clearing && (!valid_reg || q_ready);
    assign accept   = s_tvalid && s_tready;
    assign push     = valid_reg && q_ready;
    assign push_item = item_reg;

    always_comb
    begin
        item_next = item_reg;
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next          = 1'b1;
            item_next.cmd       = tlpt_pkg::cmd_t'(s_tuser);
            item_next.dir_idx   = va[31:22];
            item_next.tbl_idx   = va[21:12];
            item_next.offset    = va[11:0];
            // Page entry: frame from the physical address, flags with present forced.
            item_next.new_entry = {pa[31:12], fl | 12'h001};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

>>> rtl/core/tlpt_queue.sv
// Two-entry queue of classified requests between the front and the back part.
// Depends on tlpt_pkg.

module tlpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tlpt_pkg::item_t   push_item,
    output logic              q_ready,
    input  logic              pop,
    output tlpt_pkg::q_head_t head
);

    tlpt_pkg::item_t slots_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign q_ready    = (count_reg != 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/tlpt_back.sv
// Back part: walks directory and page table, performs map, unmap and translate.
// Depends on tlpt_pkg and tlpt_ram; also runs the clearing pass after reset.

module tlpt_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlpt_pkg::q_head_t               head,
    output logic                            pop,
    output logic                            clearing,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tlpt_pkg::OUT_DATA_W-1:0] m_tdata
);

    tlpt_pkg::back_state_t state_reg;
    tlpt_pkg::back_state_t state_next;
    tlpt_pkg::item_t       item_reg;
    tlpt_pkg::item_t       item_next;
    logic [tlpt_pkg::USED_W-1:0] used_reg;
    logic [tlpt_pkg::USED_W-1:0] used_next;
    logic [tlpt_pkg::TBL_AW-1:0] clr_cnt_reg;
    logic [tlpt_pkg::TBL_AW-1:0] clr_cnt_next;
    logic                        clr_busy_reg;
    logic                        clr_busy_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    tlpt_pkg::result_t           out_reg;
    tlpt_pkg::result_t           out_next;

    logic                             dir_we;
    logic [tlpt_pkg::LVL_W-1:0]       dir_waddr;
    logic [tlpt_pkg::DIR_W-1:0]       dir_wdata;
    logic                             dir_re;
    logic [tlpt_pkg::LVL_W-1:0]       dir_raddr;
    logic [tlpt_pkg::DIR_W-1:0]       dir_rdata;
    logic                             tbl_we;
    logic [tlpt_pkg::TBL_AW-1:0]      tbl_waddr;
    logic [31:0]                      tbl_wdata;
    logic                             tbl_re;
    logic [tlpt_pkg::TBL_AW-1:0]      tbl_raddr;
    logic [31:0]                      tbl_rdata;

    logic                             can_emit;
    logic                             slot_ok;
    logic [tlpt_pkg::SLOT_W-1:0]      dir_slot;
    logic [tlpt_pkg::SLOT_W-1:0]      new_slot;
    logic [tlpt_pkg::TBL_AW-1:0]      tbl_addr;
    logic [31:0]                      xlt_result;

    tlpt_ram #(
        .WIDTH (tlpt_pkg::DIR_W),
        .DEPTH (tlpt_pkg::ENTRIES_PER_LEVEL)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tlpt_ram #(
        .WIDTH (32),
        .DEPTH (tlpt_pkg::TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign clearing = clr_busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tlpt_pkg::OUT_DATA_W - 34){1'b0}}, out_reg};
    assign can_emit = !out_valid_reg || m_tready;

    assign dir_slot = dir_rdata[tlpt_pkg::SLOT_W-1:0];
    assign slot_ok  = dir_rdata[tlpt_pkg::DIR_W-1] && (int'(dir_slot) < tlpt_pkg::NUM_TABLES);
    assign new_slot = tlpt_pkg::SLOT_W'(used_reg);
    assign tbl_addr = {dir_slot, item_reg.tbl_idx};
    assign xlt_result = tbl_rdata[0] ? {tbl_rdata[31:12], item_reg.offset} : 32'd0;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        used_next      = used_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_busy_next  = clr_busy_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        pop            = 1'b0;
        dir_we         = 1'b0;
        dir_waddr      = item_reg.dir_idx;
        dir_wdata      = {1'b1, new_slot};
        dir_re         = 1'b0;
        dir_raddr      = head.item.dir_idx;
        tbl_we         = 1'b0;
        tbl_waddr      = tbl_addr;
        tbl_wdata      = item_reg.new_entry;
        tbl_re         = 1'b0;
        tbl_raddr      = tbl_addr;

        if (clr_busy_reg)
        begin
            // Zero one page entry and one directory entry per cycle.
            dir_we    = 1'b1;
            dir_waddr = clr_cnt_reg[tlpt_pkg::LVL_W-1:0];
            dir_wdata = '0;
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg;
            tbl_wdata = 32'd0;
            clr_cnt_next = clr_cnt_reg + tlpt_pkg::TBL_AW'(1);
            if (clr_cnt_reg == tlpt_pkg::TBL_AW'(tlpt_pkg::TBL_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        case (state_reg)
            tlpt_pkg::ST_IDLE:
            begin
                if (!clr_busy_reg && head.valid)
                begin
                    pop        = 1'b1;
                    item_next  = head.item;
                    dir_re     = 1'b1;
                    state_next = tlpt_pkg::ST_WALK;
                end
            end
            tlpt_pkg::ST_WALK:
            begin
                if (item_reg.cmd == tlpt_pkg::CMD_XLATE && slot_ok)
                begin
                    tbl_re     = 1'b1;
                    state_next = tlpt_pkg::ST_XLT;
                end
                else if (can_emit)
                begin
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = tlpt_pkg::ST_IDLE;
                    if (item_reg.cmd == tlpt_pkg::CMD_MAP)
                    begin
                        if (slot_ok)
                        begin
                            tbl_we = 1'b1;
                        end
                        else if (used_reg < tlpt_pkg::USED_W'(tlpt_pkg::NUM_TABLES))
                        begin
                            // Fresh slot: its entries are still zero from the reset pass.
                            dir_we    = 1'b1;
                            tbl_we    = 1'b1;
                            tbl_waddr = {new_slot, item_reg.tbl_idx};
                            used_next = used_reg + tlpt_pkg::USED_W'(1);
                        end
                        else
                        begin
                            out_next.status = 1'b1;
                        end
                    end
                    else if (item_reg.cmd == tlpt_pkg::CMD_UNMAP)
                    begin
                        if (slot_ok)
                        begin
                            tbl_we    = 1'b1;
                            tbl_wdata = 32'd0;
                        end
                    end
                end
            end
            tlpt_pkg::ST_XLT:
            begin
                if (can_emit)
                begin
                    out_next.status      = 1'b0;
                    out_next.phys_result = xlt_result;
                    out_next.mapped      = (xlt_result != 32'd0);
                    out_valid_next       = 1'b1;
                    state_next           = tlpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlpt_pkg::ST_IDLE;
            used_reg      <= '0;
            clr_cnt_reg   <= '0;
            clr_busy_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_busy_reg  <= clr_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

endmodule

>>> rtl/core/two_level_page_table_engine_core.sv
// Two-level page table engine: directory walk, map, unmap and translate.
// A request beat passes the front register and the queue; the back then reads the
// directory and, for translate, the page table before the result register is loaded.
// The back takes a new request only after the last result is registered, and waits
// while the result channel stalls.
// After reset, control is cleared at once, then a pass over all NUM_TABLES*1024 page entries
// (16384) zeroes the directory and page table store while no request beat is accepted.

module two_level_page_table_engine_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tlpt_pkg::IN_DATA_W-1:0]   s_tdata,  // virt_addr[31:0], phys_addr[63:32],
                                                       // page_flags[75:64], zero pad
    input  logic [1:0]                       s_tuser,  // cmd[1:0]
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tlpt_pkg::OUT_DATA_W-1:0]  m_tdata   // status[0], phys_result[32:1],
                                                       // mapped[33], zero pad
);

    // The front registers and decodes each request beat, the queue decouples it from
    // the back, and the back owns both memories and the slot pool counter. Because
    // slots are handed out in order and never returned, a freshly allocated table is
    // still all zero from the reset pass, so allocation needs no clearing sweep.

    logic              clearing;
    logic              push;
    tlpt_pkg::item_t   push_item;
    logic              q_ready;
    logic              pop;
    tlpt_pkg::q_head_t head;

    tlpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    tlpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .head      (head)
    );

    tlpt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
